@@ src/twd_pkg.sv @@
// Shared constants and types of the trie word dictionary.
`timescale 1ns / 1ps

package twd_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int USED_W        = $clog2(NODE_COUNT + 1);
  localparam int LANE_W        = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int REQ_W         = 2;
  localparam int LETTER_W      = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_PREFIX = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } st_t;

  // One child slot: the child index (0 = no child) and the end-of-word
  // mark of that child.
  typedef struct packed {
    logic              end_mark;
    logic [NODE_W-1:0] child;
  } slot_t;

  typedef slot_t [ALPHABET_SIZE-1:0] slot_row_t;

endpackage

@@ src/twd_ifs.sv @@
// Valid/ready channel interfaces for letter beats and result beats.
`timescale 1ns / 1ps

interface twd_in_if;
  import twd_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LETTER_W-1:0] letter;
  logic                last_letter;

  modport source (output valid, req_type, letter, last_letter, input ready);
  modport sink   (input valid, req_type, letter, last_letter, output ready);
endinterface

interface twd_out_if;
  logic valid;
  logic ready;
  logic found;
  logic pool_overflow;

  modport source (output valid, found, pool_overflow, input ready);
  modport sink   (input valid, found, pool_overflow, output ready);
endinterface

@@ src/trie_word_dictionary_top.sv @@
// Trie word dictionary: letter-serial insert, exact search and prefix search.
// A letter beat is accepted in the idle state, where its node row is read into
// a register, then looked up and committed in the update state; a result beat
// is registered onto out_ch when its last letter commits. No new letter is
// taken until the previous one commits; a result waiting on a full out_ch
// holds the update state until the previous result beat leaves.
// Reset: synchronous on rst_n low; a clearing sweep of all NODE_COUNT (1024)
// rows follows, one row a cycle, with in_ch.ready low until it is done.
`timescale 1ns / 1ps

module trie_word_dictionary_top (
  input  logic     clk,
  input  logic     rst_n,
  twd_in_if.sink   in_ch,
  twd_out_if.source out_ch
);
  import twd_pkg::*;

  // Node row memory: one row per node, one slot per letter. The end mark of
  // a node sits in its parent's slot, so a single read answers both the
  // child lookup and the exact-search check.
  slot_row_t child_mem [NODE_COUNT];
  slot_row_t row_q;

  // Control state
  st_t               state_r, state_nxt;
  logic [NODE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [USED_W-1:0] nodes_used_r;
  logic [NODE_W-1:0] current_node_r;
  logic              word_missed_r;
  logic              word_overflowed_r;
  logic              out_valid_r;

  // Held letter beat
  req_t                req_r;
  logic [LETTER_W-1:0] letter_r;
  logic                last_r;

  // Result payload
  logic found_r;
  logic pool_overflow_r;

  // Memory port controls
  logic                     rd_en;
  logic                     mem_we;
  logic [NODE_W-1:0]        wr_addr;
  logic [ALPHABET_SIZE-1:0] wr_mask;
  slot_t                    wr_slot;

  // Walk of one letter
  logic                     in_range;
  logic [LANE_W-1:0]        lane;
  logic [ALPHABET_SIZE-1:0] lane_mask;
  slot_t                    cur_slot;
  logic [NODE_W-1:0]        walk_node;
  logic [USED_W-1:0]        walk_used;
  logic                     walk_missed;
  logic                     walk_ovf;
  logic                     walk_wr;
  slot_t                    walk_slot;
  logic                     res_valid;
  logic                     res_found;
  logic                     res_ovf;

  logic in_ready;
  logic item_ld;
  logic commit;

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = found_r;
  assign out_ch.pool_overflow = pool_overflow_r;

  // Letter decode: letters past the alphabet have no child and never index
  // the row.
  assign in_range = int'(letter_r) < ALPHABET_SIZE;
  assign lane     = LANE_W'(letter_r);
  assign cur_slot = in_range ? row_q[lane] : '0;

  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      lane_mask[i] = (lane == LANE_W'(i));
    end
  end

  // Walk one step from the current node, using the registered row read when the letter was accepted.
  always_comb begin
    walk_node   = current_node_r;
    walk_used   = nodes_used_r;
    walk_missed = word_missed_r;
    walk_ovf    = word_overflowed_r;
    walk_wr     = 1'b0;
    walk_slot   = '0;
    res_valid   = 1'b0;
    res_found   = 1'b0;
    res_ovf     = 1'b0;
    unique case (req_r)
      REQ_INSERT: begin
        if (!word_missed_r && !word_overflowed_r) begin
          if (!in_range) begin
            walk_missed = 1'b1;
          end else if (cur_slot.child != '0) begin
            walk_node = cur_slot.child;
          end else if (nodes_used_r < USED_W'(NODE_COUNT)) begin
            // Take the next free node and link it in
            walk_node = nodes_used_r[NODE_W-1:0];
            walk_used = nodes_used_r + 1'b1;
            walk_wr   = 1'b1;
          end else begin
            walk_ovf = 1'b1;
          end
        end
        // A clean last letter marks the word end in the slot just walked
        if (last_r && !walk_missed && !walk_ovf) begin
          walk_wr = 1'b1;
        end
        walk_slot.end_mark = last_r;
        walk_slot.child    = walk_node;
        res_valid = last_r;
        res_found = !walk_missed && !walk_ovf;
        res_ovf   = walk_ovf;
      end
      REQ_SEARCH, REQ_PREFIX: begin
        if (!word_missed_r) begin
          if (!in_range || cur_slot.child == '0) begin
            walk_missed = 1'b1;
          end else begin
            walk_node = cur_slot.child;
          end
        end
        res_valid = last_r;
        res_found = !walk_missed && (req_r == REQ_PREFIX || cur_slot.end_mark);
      end
      REQ_NONE: begin
      end
    endcase
    // Every last letter sends the walk back to the root
    if (last_r) begin
      walk_node   = '0;
      walk_missed = 1'b0;
      walk_ovf    = 1'b0;
    end
  end

  // Sequencer: clear sweep, then accept a letter, then look it up and commit.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_ready    = 1'b0;
    item_ld     = 1'b0;
    rd_en       = 1'b0;
    commit      = 1'b0;
    mem_we      = 1'b0;
    wr_addr     = current_node_r;
    wr_mask     = lane_mask;
    wr_slot     = walk_slot;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_mask     = '1;
        wr_slot     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          item_ld   = 1'b1;
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold while a result is due and the output register is still full
        if (!(res_valid && out_valid_r && !out_ch.ready)) begin
          commit    = 1'b1;
          mem_we    = walk_wr;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_CLEAR;
      clr_cnt_r         <= '0;
      nodes_used_r      <= USED_W'(1);
      current_node_r    <= '0;
      word_missed_r     <= 1'b0;
      word_overflowed_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (commit) begin
        nodes_used_r      <= walk_used;
        current_node_r    <= walk_node;
        word_missed_r     <= walk_missed;
        word_overflowed_r <= walk_ovf;
      end
      if (commit && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers; the request type and last mark start idle so the walk
  // decodes nothing before the first beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= REQ_NONE;
      last_r <= 1'b0;
    end else if (item_ld) begin
      req_r    <= req_t'(in_ch.req_type);
      letter_r <= in_ch.letter;
      last_r   <= in_ch.last_letter;
    end
    if (commit && res_valid) begin
      found_r         <= res_found;
      pool_overflow_r <= res_ovf;
    end
  end

  // Row memory: one registered read port, one write port with slot enables
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q <= child_mem[current_node_r];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        if (wr_mask[i]) begin
          child_mem[wr_addr][i] <= wr_slot;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_pool_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r >= USED_W'(1) && nodes_used_r <= USED_W'(NODE_COUNT))
    else $error("node pool count out of bounds");

  a_node_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    USED_W'(current_node_r) < nodes_used_r)
    else $error("walk points at a node not yet allocated");

  a_pool_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (nodes_used_r == $past(nodes_used_r) ||
                      nodes_used_r == $past(nodes_used_r) + 1'b1))
    else $error("node pool grew by more than one");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result beat raised outside the update cycle");
`endif

endmodule

@@ sim/tb_trie_word_dictionary_top.sv @@
// Testbench for the trie word dictionary: queued letter stimulus, trie predictor, result checks.
`timescale 1ns / 1ps

module tb_trie_word_dictionary_top;
  import twd_pkg::*;

  // The block sees no beat for a long time after reset (the clearing sweep),
  // and once more during the long receiver hold-off; both are far below this.
  localparam int STALL_LIMIT  = 8000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 80;   // letter beats accepted before the hold-off
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_WORD     = 12;
  localparam int POOL_MARGIN  = 24;   // planned nodes past the pool size

  // One letter beat as queued for the driver; drain asks the driver to wait
  // until every pending lookup result has come back before offering it.
  typedef struct packed {
    req_t                req;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                drain;
  } letter_beat_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } lookup_result_t;

  typedef struct packed {
    logic [3:0]                        len;
    logic [MAX_WORD-1:0][LETTER_W-1:0] l;
  } word_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  twd_in_if  in_ch ();
  twd_out_if out_ch ();

  trie_word_dictionary_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Trie predictor: its own copy of the node pool, child slots and end marks.
  // ---------------------------------------------------------------------------
  bit [NODE_W-1:0] trie_kids [NODE_COUNT*ALPHABET_SIZE];
  bit              word_end  [NODE_COUNT];
  int unsigned     pool_fill = 1;    // root is taken
  int unsigned     walk_pos  = 0;
  bit              walk_dead = 0;    // path left the tree, rest of word ignored
  bit              walk_full = 0;    // insert ran out of nodes

  function automatic void rewind_walk();
    walk_pos  = 0;
    walk_dead = 0;
    walk_full = 0;
  endfunction

  // Advance the walk by one letter; emits is set on a last letter not of the unused request type.
  function automatic void trie_step(input letter_beat_t b, output bit emits,
                                    output lookup_result_t res);
    int unsigned slot;
    emits = 1'b0;
    res   = '0;
    // The unused request type only ends the word, silently.
    if (b.req == REQ_NONE) begin
      if (b.last) rewind_walk();
      return;
    end
    if (b.req == REQ_INSERT) begin
      if (!walk_dead && !walk_full) begin
        if (b.letter >= ALPHABET_SIZE) begin
          walk_dead = 1'b1;
        end else begin
          slot = walk_pos * ALPHABET_SIZE + b.letter;
          if (trie_kids[slot] != 0) begin
            walk_pos = trie_kids[slot];
          end else if (pool_fill < NODE_COUNT) begin
            trie_kids[slot] = pool_fill[NODE_W-1:0];
            walk_pos        = pool_fill;
            pool_fill++;
          end else begin
            walk_full = 1'b1;
          end
        end
      end
    end else if (!walk_dead) begin
      if (b.letter >= ALPHABET_SIZE) begin
        walk_dead = 1'b1;
      end else begin
        slot = walk_pos * ALPHABET_SIZE + b.letter;
        if (trie_kids[slot] == 0) walk_dead = 1'b1;
        else walk_pos = trie_kids[slot];
      end
    end
    if (!b.last) return;
    emits = 1'b1;
    // The result follows the type of the last letter only.
    if (b.req == REQ_INSERT) begin
      res.found    = !walk_dead && !walk_full;
      res.overflow = walk_full;
      if (res.found) word_end[walk_pos] = 1'b1;
    end else begin
      res.found    = !walk_dead && (b.req == REQ_PREFIX || word_end[walk_pos]);
      res.overflow = 1'b0;
    end
    rewind_walk();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store, expected results and mismatch reporting.
  // ---------------------------------------------------------------------------
  letter_beat_t   letter_q [$];
  lookup_result_t lookup_q [$];
  int             mismatches = 0;
  int             results_seen = 0;
  bit             drain_next = 1'b0;
  bit             planned_prefix [string];
  int             planned_nodes = 1;

  task automatic report_mismatch(input string what);
    $display("MISMATCH result %0d %s", results_seen, what);
    mismatches++;
  endtask

  task automatic push_beat(input req_t req, input logic [LETTER_W-1:0] letter,
                           input logic last);
    letter_beat_t b;
    b.req    = req;
    b.letter = letter;
    b.last   = last;
    b.drain  = drain_next;
    drain_next = 1'b0;
    letter_q.push_back(b);
  endtask

  // Push the first upto letters of a word, the last of them marked.
  task automatic push_word(input req_t req, input word_rec_t w, input int upto);
    for (int i = 0; i < upto; i++) push_beat(req, w.l[i], i == upto - 1);
  endtask

  // Tally the nodes a full insert of w would take, to steer the pool to its end.
  function automatic void plan_insert(input word_rec_t w);
    string key;
    key = "";
    for (int i = 0; i < w.len; i++) begin
      if (w.l[i] >= ALPHABET_SIZE) break;
      key = $sformatf("%s%0d.", key, w.l[i]);
      if (!planned_prefix.exists(key)) begin
        planned_prefix[key] = 1'b1;
        planned_nodes++;
      end
    end
  endfunction

  // Random word; bad_pct is the chance per letter of an out-of-range letter.
  function automatic word_rec_t rand_word(input int lo_len, input int hi_len,
                                          input int top_letter, input int bad_pct);
    word_rec_t w;
    w     = '0;
    w.len = 4'($urandom_range(hi_len, lo_len));
    for (int i = 0; i < w.len; i++) begin
      if ($urandom_range(99, 0) < bad_pct)
        w.l[i] = LETTER_W'($urandom_range(31, ALPHABET_SIZE));
      else w.l[i] = LETTER_W'($urandom_range(top_letter, 0));
    end
    return w;
  endfunction

  // Unstructured beat: any type, any 5-bit letter, occasional last mark.
  task automatic push_noise();
    push_beat(req_t'($urandom_range(3, 0)), LETTER_W'($urandom_range(31, 0)),
              $urandom_range(2, 0) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts with random gaps, fed from letter_q.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    letter_beat_t   head;
    bit             emits;
    lookup_result_t res;
    logic           next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Retire the beat taken at this edge and predict its result.
      if (in_ch.valid && in_ch.ready) begin
        head = letter_q.pop_front();
        trie_step(head, emits, res);
        if (emits) lookup_q.push_back(res);
      end
      // Hold a beat that is still waiting; otherwise pick the next move.
      if (!(in_ch.valid && !in_ch.ready)) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (letter_q.size() != 0 &&
                     !(letter_q[0].drain && lookup_q.size() != 0)) begin
          head            = letter_q[0];
          next_valid      = 1'b1;
          in_ch.req_type    <= head.req;
          in_ch.letter      <= head.letter;
          in_ch.last_letter <= head.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Mostly short bursts; now and then a long run with no gap at all.
            if ($urandom_range(3, 0) == 0) begin
              burst_left = $urandom_range(120, 40);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(16, 1);
              gap_left   = $urandom_range(7, 0);
            end
          end
        end
        in_ch.valid <= next_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern that changes mode, plus one long hold-off.
  // ---------------------------------------------------------------------------
  int unsigned sink_mode  = 0;
  int unsigned mode_left  = 0;
  int unsigned sink_tick  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  int unsigned beats_seen = 0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      sink_tick++;
      if (in_ch.valid && in_ch.ready) beats_seen++;
      // Starve the output for a long stretch once, so the block backs up.
      if (!hold_done && beats_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = $urandom_range(3, 0);
          mode_left = $urandom_range(96, 16);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(1, 0));
          2:       rdy = ($urandom_range(4, 0) != 0);
          default: rdy = (sink_tick % 3) != 0;
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        report_mismatch("arrived with nothing pending");
      end else begin
        want = lookup_q.pop_front();
        if (out_ch.found !== want.found)
          report_mismatch($sformatf("found: got %0b expected %0b",
                                    out_ch.found, want.found));
        if (out_ch.pool_overflow !== want.overflow)
          report_mismatch($sformatf("pool_overflow: got %0b expected %0b",
                                    out_ch.pool_overflow, want.overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either channel for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    word_rec_t w;
    word_rec_t short_words [$];
    word_rec_t long_words [$];
    int        roll;
    int        cut;

    // Known values on every input from time zero.
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_INSERT;
    in_ch.letter      = '0;
    in_ch.last_letter = 1'b0;
    out_ch.ready      = 1'b0;

    // Directed: letter extremes, every request type, misses, out-of-range
    // letters, aborted words and a type change inside a word.
    push_beat(REQ_INSERT, 5'd0, 1'b1);                                 // "a"
    push_beat(REQ_INSERT, 5'd25, 1'b0); push_beat(REQ_INSERT, 5'd25, 1'b1); // "zz"
    push_beat(REQ_SEARCH, 5'd25, 1'b0); push_beat(REQ_SEARCH, 5'd25, 1'b1); // hit
    push_beat(REQ_SEARCH, 5'd25, 1'b1);                                 // no end mark
    push_beat(REQ_PREFIX, 5'd25, 1'b1);                                 // path exists
    push_beat(REQ_SEARCH, 5'd0, 1'b1);
    push_beat(REQ_PREFIX, 5'd3, 1'b0); push_beat(REQ_PREFIX, 5'd4, 1'b1);  // missing child
    push_beat(REQ_SEARCH, 5'd31, 1'b1);                                 // letter out of range
    push_beat(REQ_INSERT, 5'd26, 1'b1);                                 // insert out of range
    push_beat(REQ_INSERT, 5'd1, 1'b0); push_beat(REQ_INSERT, 5'd30, 1'b0);
    push_beat(REQ_INSERT, 5'd2, 1'b1);                                  // rest dropped
    push_beat(REQ_NONE, 5'd5, 1'b0);                                    // ignored
    push_beat(REQ_INSERT, 5'd2, 1'b0); push_beat(REQ_NONE, 5'd9, 1'b1); // aborted insert
    push_beat(REQ_PREFIX, 5'd2, 1'b1);                                  // node left behind
    push_beat(REQ_SEARCH, 5'd2, 1'b1);                                  // but unmarked
    push_beat(REQ_INSERT, 5'd7, 1'b0); push_beat(REQ_SEARCH, 5'd7, 1'b1);  // type change
    push_beat(REQ_PREFIX, 5'd25, 1'b0); push_beat(REQ_INSERT, 5'd1, 1'b1);  // type change
    push_beat(REQ_SEARCH, 5'd25, 1'b0); push_beat(REQ_SEARCH, 5'd1, 1'b1);
    planned_nodes = 6;

    // Phase one: small alphabet and short words so searches often hit.
    while (letter_q.size() < 90) begin
      roll = $urandom_range(99, 0);
      if (roll < 35 || short_words.size() == 0) begin
        w = rand_word(1, 4, 3, 0);
        short_words.push_back(w);
        plan_insert(w);
        push_word(REQ_INSERT, w, w.len);
      end else if (roll < 65) begin
        w = short_words[$urandom_range(short_words.size() - 1, 0)];
        // Sometimes only a part of a stored word, which may miss the end mark.
        push_word(REQ_SEARCH, w,
                  ($urandom_range(3, 0) == 0) ? $urandom_range(w.len, 1) : w.len);
      end else if (roll < 80) begin
        w = short_words[$urandom_range(short_words.size() - 1, 0)];
        if ($urandom_range(3, 0) == 0) w = rand_word(1, 4, 5, 0);
        push_word(REQ_PREFIX, w, $urandom_range(w.len, 1));
      end else if (roll < 90) begin
        // Broken word: a stored word, possibly cut short, sent under random request
        // types and sometimes ended with the unused type.
        w   = short_words[$urandom_range(short_words.size() - 1, 0)];
        cut = $urandom_range(w.len, 1);
        for (int i = 0; i < cut - 1; i++)
          push_beat(req_t'($urandom_range(2, 0)), w.l[i], 1'b0);
        push_beat(req_t'($urandom_range(3, 0)), w.l[cut-1], 1'b1);
      end else begin
        push_noise();
      end
    end

    // Phase two: long words over the full alphabet to use up the node pool.
    // Let the block settle first.
    drain_next = 1'b1;
    while (planned_nodes < NODE_COUNT + POOL_MARGIN) begin
      roll = $urandom_range(99, 0);
      if (roll < 92 || long_words.size() == 0) begin
        w = rand_word(6, MAX_WORD, ALPHABET_SIZE - 1, 1);
        long_words.push_back(w);
        plan_insert(w);
        push_word(REQ_INSERT, w, w.len);
      end else if (roll < 97) begin
        w = long_words[$urandom_range(long_words.size() - 1, 0)];
        if ($urandom_range(1, 0) == 0) push_word(REQ_SEARCH, w, w.len);
        else push_word(REQ_PREFIX, w, $urandom_range(w.len, 1));
      end else begin
        push_noise();
      end
    end

    // Phase three: pool is spent; known words still insert, new ones overflow.
    for (int k = 0; k < 20; k++) begin
      roll = $urandom_range(99, 0);
      if (roll < 30) begin
        w = long_words[$urandom_range(long_words.size() - 1, 0)];
        push_word(REQ_INSERT, w, w.len);
      end else if (roll < 55) begin
        w = rand_word(2, 6, ALPHABET_SIZE - 1, 5);
        push_word(REQ_INSERT, w, w.len);
      end else if (roll < 80) begin
        w = short_words[$urandom_range(short_words.size() - 1, 0)];
        push_word(req_t'($urandom_range(2, 0)), w, w.len);
      end else begin
        push_noise();
      end
    end
    // Close any word the noise left open.
    push_beat(REQ_NONE, 5'd0, 1'b1);

    // Single synchronous reset pulse.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to go in and every result to come out.
    @(posedge clk);
    while (letter_q.size() != 0 || in_ch.valid || lookup_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ trie_word_dictionary_top.f @@
src/twd_pkg.sv
src/twd_ifs.sv
src/trie_word_dictionary_top.sv
sim/tb_trie_word_dictionary_top.sv
